[design/edge_coverage_counter_core_macros.svh]
// Assertion macros for the edge coverage counter checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EDGE_COVERAGE_COUNTER_CORE_MACROS_SVH
`define EDGE_COVERAGE_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ECC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edge coverage counter assertion failed");

// Next-cycle implication, disabled during reset.
`define ECC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edge coverage counter assertion failed");

`endif

[design/ecc_pkg.sv]
// Shared types and constants for the edge coverage counter.
// No dependencies; used by every other file of the block but the assertion macro header.
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int unsigned IDX_W      = 16;
  localparam int unsigned PREV_W     = 15;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned UNIQUE_W   = 17;
  localparam int unsigned TOTAL_W    = 64;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LOG2_W     = 5;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [LOG2_W-1:0] DEF_LOG2  = 5'd16;
  localparam logic [LOG2_W-1:0] MIN_LOG2  = 5'd10;
  localparam logic [LOG2_W-1:0] MAX_LOG2  = 5'd16;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_TRACE    = 2'd0,
    OP_NEW_CASE = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } back_state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

[design/ecc_if.sv]
// Valid/ready channel interfaces for the edge coverage counter.
// Depends on ecc_pkg for field widths.
`timescale 1ns / 1ps

interface ecc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [ecc_pkg::ADDR_W-1:0]    block_address;
  logic [ecc_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, output operation, output block_address,
                  output read_index, input ready);
  modport sink   (input valid, input operation, input block_address,
                  input read_index, output ready);
endinterface

interface ecc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ecc_pkg::IDX_W-1:0]     edge_index;
  logic [ecc_pkg::CNT_W-1:0]     hit_count;
  logic                          first_hit;
  logic [ecc_pkg::UNIQUE_W-1:0]  unique_edge_count;
  logic [ecc_pkg::TOTAL_W-1:0]   total_trace_count;

  modport source (output valid, output edge_index, output hit_count,
                  output first_hit, output unique_edge_count,
                  output total_trace_count, input ready);
  modport sink   (input valid, input edge_index, input hit_count,
                  input first_hit, input unique_edge_count,
                  input total_trace_count, output ready);
endinterface

[design/edge_coverage_counter_core.sv]
// Edge coverage counter: one result per item; the back end reads the counter memory in
// one state and updates it in the next, and pops no new item until that result is loaded.
// An item passes the queue slot, the memory read register and the output register.
// Reset clears control and counts; a clearing pass over all MAP_ENTRIES entries then
// zeroes the counter memory, and no item is taken until it ends.
// Config writes are taken at all times. Depends on ecc_pkg, ecc_if, submodules.
`timescale 1ns / 1ps

module edge_coverage_counter_core #(
  parameter int unsigned MAP_ENTRIES = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ecc_pkg::LOG2_W-1:0]  cfg_wdata_i,
  ecc_in_if.sink                      in_i,
  ecc_out_if.source                   out_o
);

  logic          clearing, q_full, push, pop, q_valid;
  ecc_pkg::cmd_t push_cmd, pop_cmd;

  ecc_front #(.MAP_ENTRIES(MAP_ENTRIES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  ecc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  ecc_back #(.MAP_ENTRIES(MAP_ENTRIES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule

[design/ecc_front.sv]
// Front end: map size register, previous location and edge index computation.
// Depends on ecc_pkg and ecc_in_if; pushes commands into ecc_queue.
`timescale 1ns / 1ps

module ecc_front #(
  parameter int unsigned MAP_ENTRIES = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ecc_pkg::LOG2_W-1:0]  cfg_wdata_i,
  ecc_in_if.sink                      in_i,
  input  logic                        clearing_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output ecc_pkg::cmd_t               cmd_o
);

  localparam logic [ecc_pkg::IDX_W-1:0] PHYS_MASK = ecc_pkg::IDX_W'(MAP_ENTRIES - 1);

  logic [ecc_pkg::LOG2_W-1:0] map_size_q;
  logic [ecc_pkg::PREV_W-1:0] prev_q, prev_d;
  logic [ecc_pkg::LOG2_W-1:0] lg;
  logic [ecc_pkg::IDX_W-1:0]  mask, fold, cur, trace_idx;

  assign in_i.ready = !clearing_i && !q_full_i;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    lg = map_size_q;
    if (lg < ecc_pkg::MIN_LOG2 || lg > ecc_pkg::MAX_LOG2) begin
      lg = ecc_pkg::DEF_LOG2;
    end
    mask      = ecc_pkg::IDX_W'((17'd1 << lg) - 17'd1) & PHYS_MASK;
    fold      = in_i.block_address[15:0] ^ in_i.block_address[31:16];
    cur       = fold & mask;
    trace_idx = (cur ^ {1'b0, prev_q}) & mask;
  end

  always_comb begin
    prev_d    = prev_q;
    cmd_o.op  = in_i.operation;
    cmd_o.idx = '0;
    case (ecc_pkg::op_e'(in_i.operation))
      ecc_pkg::OP_TRACE: begin
        cmd_o.idx = trace_idx;
        if (push_o) begin
          prev_d = cur[ecc_pkg::IDX_W-1:1];
        end
      end
      ecc_pkg::OP_NEW_CASE: begin
        if (push_o) begin
          prev_d = '0;
        end
      end
      ecc_pkg::OP_READ: begin
        cmd_o.idx = in_i.read_index & PHYS_MASK;
      end
      default: begin
        cmd_o.idx = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= ecc_pkg::DEF_LOG2;
      prev_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        map_size_q <= cfg_wdata_i;
      end
      prev_q <= prev_d;
    end
  end

endmodule

[design/ecc_queue.sv]
// Two-entry command queue between front end and back end.
// Depends on ecc_pkg for the command type.
`timescale 1ns / 1ps

module ecc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ecc_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ecc_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(ecc_pkg::QDEPTH);
  localparam int unsigned CNT_W = $clog2(ecc_pkg::QDEPTH + 1);

  ecc_pkg::cmd_t    slots_q [ecc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_W'(ecc_pkg::QDEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(ecc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(ecc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/ecc_back.sv]
// Back end: hit counter memory with clearing pass, read-modify-write, counts.
// Depends on ecc_pkg and ecc_out_if; pops commands from ecc_queue.
`timescale 1ns / 1ps

module ecc_back #(
  parameter int unsigned MAP_ENTRIES = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ecc_pkg::cmd_t q_cmd_i,
  output logic          pop_o,
  output logic          clearing_o,
  ecc_out_if.source     out_o
);

  localparam int unsigned AW = $clog2(MAP_ENTRIES);

  logic [ecc_pkg::CNT_W-1:0] mem [MAP_ENTRIES];

  ecc_pkg::back_state_e         state_q, state_d;
  logic [AW-1:0]                clr_q, clr_d;
  ecc_pkg::cmd_t                cmd_q, cmd_d;
  logic [ecc_pkg::CNT_W-1:0]    rdata_q;
  logic                         re, we;
  logic [AW-1:0]                raddr, waddr;
  logic [ecc_pkg::CNT_W-1:0]    wdata;

  logic [ecc_pkg::UNIQUE_W-1:0] unique_q, unique_d;
  logic [ecc_pkg::TOTAL_W-1:0]  total_q, total_d;

  logic                         ovalid_q, ovalid_d, load;
  logic [ecc_pkg::IDX_W-1:0]    oidx_q, oidx_d;
  logic [ecc_pkg::CNT_W-1:0]    ocnt_q, ocnt_d;
  logic                         ofirst_q, ofirst_d;

  assign clearing_o                = (state_q == ecc_pkg::ST_CLEAR);
  assign out_o.valid               = ovalid_q;
  assign out_o.edge_index          = oidx_q;
  assign out_o.hit_count           = ocnt_q;
  assign out_o.first_hit           = ofirst_q;
  assign out_o.unique_edge_count   = unique_q;
  assign out_o.total_trace_count   = total_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    pop_o    = 1'b0;
    re       = 1'b0;
    raddr    = q_cmd_i.idx[AW-1:0];
    we       = 1'b0;
    waddr    = cmd_q.idx[AW-1:0];
    wdata    = rdata_q + 1'b1;
    unique_d = unique_q;
    total_d  = total_q;
    load     = 1'b0;
    oidx_d   = oidx_q;
    ocnt_d   = ocnt_q;
    ofirst_d = ofirst_q;
    case (state_q)
      ecc_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(MAP_ENTRIES - 1)) begin
          state_d = ecc_pkg::ST_IDLE;
        end
      end
      ecc_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          re      = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = ecc_pkg::ST_READ;
        end
      end
      ecc_pkg::ST_READ: begin
        if (!ovalid_q || out_o.ready) begin
          load     = 1'b1;
          state_d  = ecc_pkg::ST_IDLE;
          oidx_d   = cmd_q.idx;
          ocnt_d   = '0;
          ofirst_d = 1'b0;
          case (ecc_pkg::op_e'(cmd_q.op))
            ecc_pkg::OP_TRACE: begin
              total_d = total_q + 1'b1;
              ocnt_d  = rdata_q;
              if (rdata_q != ecc_pkg::COUNT_MAX) begin
                we     = 1'b1;
                ocnt_d = wdata;
                if (rdata_q == '0) begin
                  ofirst_d = 1'b1;
                  unique_d = unique_q + 1'b1;
                end
              end
            end
            ecc_pkg::OP_READ: begin
              ocnt_d = rdata_q;
            end
            default: begin
              oidx_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ecc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      oidx_q   <= oidx_d;
      ocnt_q   <= ocnt_d;
      ofirst_q <= ofirst_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecc_pkg::ST_CLEAR;
      clr_q    <= '0;
      unique_q <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      unique_q <= unique_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[design/ecc_checker.sv]
// Port-level assertions for the edge coverage counter, bound to the top level.
// Depends on ecc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "edge_coverage_counter_core_macros.svh"

module ecc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [ecc_pkg::IDX_W-1:0]     out_edge_index_i,
  input logic [ecc_pkg::CNT_W-1:0]     out_hit_count_i,
  input logic                          out_first_hit_i,
  input logic [ecc_pkg::UNIQUE_W-1:0]  out_unique_i,
  input logic [ecc_pkg::TOTAL_W-1:0]   out_total_i
);

  `ECC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_edge_index_i) && $stable(out_hit_count_i) && $stable(out_first_hit_i) && $stable(out_unique_i) && $stable(out_total_i))
  `ECC_ASSERT_NOW(a_first_hit_one, out_valid_i && out_first_hit_i, out_hit_count_i == 8'd1)
  `ECC_ASSERT_NOW(a_first_hit_counted, out_valid_i && out_first_hit_i, out_unique_i != '0 && out_total_i != '0)
  `ECC_ASSERT_NOW(a_clear_blocks_input, $past(!rst_ni), !in_ready_i)

endmodule

bind edge_coverage_counter_core ecc_checker u_ecc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_edge_index_i (out_o.edge_index),
  .out_hit_count_i  (out_o.hit_count),
  .out_first_hit_i  (out_o.first_hit),
  .out_unique_i     (out_o.unique_edge_count),
  .out_total_i      (out_o.total_trace_count)
);

[sim/edge_coverage_counter_core_tb.sv]
// Testbench for edge_coverage_counter_core: directed and random trace, new-case and read
// transfers, checked by a scoreboard that keeps its own copy of the hit map and counts.
// Depends on ecc_pkg and ecc_if from the design folder.
`timescale 1ns / 1ps

module edge_coverage_counter_core_tb;

  localparam int unsigned MAP_DEPTH = 65536;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned HOT_LOOP_ITEMS = 300;
  localparam int unsigned MAX_REPORTS = 40;

  typedef enum int {
    RX_ALWAYS,
    RX_RUNS,
    RX_RANDOM
  } rx_mode_e;

  typedef struct packed {
    logic [ecc_pkg::IDX_W-1:0]    edge_index;
    logic [ecc_pkg::CNT_W-1:0]    hit_count;
    logic                         first_hit;
    logic [ecc_pkg::UNIQUE_W-1:0] unique_edge_count;
    logic [ecc_pkg::TOTAL_W-1:0]  total_trace_count;
  } coverage_result_t;

  class coverage_map_scoreboard;
    bit [ecc_pkg::CNT_W-1:0]    hit_map [MAP_DEPTH];
    bit [ecc_pkg::PREV_W-1:0]   prev_location;
    bit [ecc_pkg::UNIQUE_W-1:0] seen_edges;
    bit [ecc_pkg::TOTAL_W-1:0]  total_traces;
    bit [ecc_pkg::LOG2_W-1:0]   map_log2;
    bit [ecc_pkg::IDX_W-1:0]    last_edge;
    coverage_result_t           expected_q[$];

    function new();
      map_log2 = ecc_pkg::DEF_LOG2;
    endfunction

    function bit [ecc_pkg::IDX_W-1:0] map_mask();
      bit [ecc_pkg::LOG2_W-1:0] lg;
      bit [31:0]                full;
      lg = map_log2;
      if (lg < ecc_pkg::MIN_LOG2) lg = ecc_pkg::DEF_LOG2;
      if (lg > ecc_pkg::MAX_LOG2) lg = ecc_pkg::MAX_LOG2;
      full = (32'd1 << lg) - 32'd1;
      return full[ecc_pkg::IDX_W-1:0];
    endfunction

    function void note_transfer(logic [1:0] op, logic [ecc_pkg::ADDR_W-1:0] addr,
                                logic [ecc_pkg::IDX_W-1:0] ridx);
      coverage_result_t          res;
      bit [ecc_pkg::IDX_W-1:0]   mask;
      bit [ecc_pkg::IDX_W-1:0]   cur;
      res = '0;
      if (op == ecc_pkg::OP_TRACE) begin
        mask = map_mask();
        cur = (addr[15:0] ^ addr[31:16]) & mask;
        res.edge_index = (cur ^ {1'b0, prev_location}) & mask;
        res.hit_count = hit_map[res.edge_index];
        if (res.hit_count != ecc_pkg::COUNT_MAX) begin
          if (res.hit_count == '0) begin
            res.first_hit = 1'b1;
            seen_edges++;
          end
          res.hit_count++;
          hit_map[res.edge_index] = res.hit_count;
        end
        prev_location = cur[ecc_pkg::IDX_W-1:1];
        total_traces++;
        last_edge = res.edge_index;
      end else if (op == ecc_pkg::OP_NEW_CASE) begin
        prev_location = '0;
      end else if (op == ecc_pkg::OP_READ) begin
        res.edge_index = ridx;
        res.hit_count = hit_map[ridx];
      end
      res.unique_edge_count = seen_edges;
      res.total_trace_count = total_traces;
      expected_q.push_back(res);
    endfunction

    function string check_result(coverage_result_t got);
      coverage_result_t exp;
      string            msg;
      if (expected_q.size() == 0)
        return $sformatf(" unexpected result, edge_index %0h", got.edge_index);
      exp = expected_q.pop_front();
      msg = "";
      if (got.edge_index !== exp.edge_index)
        msg = {msg, $sformatf(" edge_index %0h exp %0h", got.edge_index, exp.edge_index)};
      if (got.hit_count !== exp.hit_count)
        msg = {msg, $sformatf(" hit_count %0d exp %0d", got.hit_count, exp.hit_count)};
      if (got.first_hit !== exp.first_hit)
        msg = {msg, $sformatf(" first_hit %0b exp %0b", got.first_hit, exp.first_hit)};
      if (got.unique_edge_count !== exp.unique_edge_count)
        msg = {msg, $sformatf(" unique %0d exp %0d", got.unique_edge_count,
                              exp.unique_edge_count)};
      if (got.total_trace_count !== exp.total_trace_count)
        msg = {msg, $sformatf(" total %0d exp %0d", got.total_trace_count,
                              exp.total_trace_count)};
      return msg;
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [ecc_pkg::LOG2_W-1:0] cfg_wdata_i;

  ecc_in_if  in_if ();
  ecc_out_if out_if ();

  coverage_map_scoreboard sb;
  int unsigned mismatch_count = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;
  bit          long_hold_req = 1'b0;
  bit          gaps_on = 1'b0;
  int unsigned burst_left = 0;

  edge_coverage_counter_core #(
    .MAP_ENTRIES(MAP_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH @%0t:%s", $time, what);
  endtask

  // Check the result transfer first, then record the input transfer of the same edge.
  always @(posedge clk_i) begin
    coverage_result_t got;
    string            msg;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.edge_index = out_if.edge_index;
        got.hit_count = out_if.hit_count;
        got.first_hit = out_if.first_hit;
        got.unique_edge_count = out_if.unique_edge_count;
        got.total_trace_count = out_if.total_trace_count;
        msg = sb.check_result(got);
        if (msg != "") report_mismatch(msg);
      end
      if (in_if.valid && in_if.ready)
        sb.note_transfer(in_if.operation, in_if.block_address, in_if.read_index);
    end
  end

  initial begin : receiver
    int unsigned run_left;
    int unsigned hold_left;
    bit          hold_seen;
    bit          rx_level;
    run_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    rx_level = 1'b1;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_if.ready <= 1'b1;
          RX_RUNS: begin
            if (run_left == 0) begin
              rx_level = ~rx_level;
              run_left = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            out_if.ready <= rx_level;
          end
          default: out_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic drive_item(logic [1:0] op, logic [ecc_pkg::ADDR_W-1:0] addr,
                            logic [ecc_pkg::IDX_W-1:0] ridx);
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.block_address <= addr;
    in_if.read_index <= ridx;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_map_log2(logic [ecc_pkg::LOG2_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    sb.map_log2 = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hammer one entry: addresses with equal halves fold to zero and keep the edge fixed.
  task automatic hot_loop(int unsigned n);
    logic [15:0] half;
    repeat (n) begin
      half = 16'($urandom());
      if ($urandom_range(0, 9) == 0)
        drive_item(ecc_pkg::OP_READ, $urandom(),
                   ($urandom_range(0, 1) != 0) ? 16'h0000 : sb.last_edge);
      else
        drive_item(ecc_pkg::OP_TRACE, {half, half}, 16'($urandom()));
    end
  endtask

  task automatic random_phase(int unsigned n);
    logic [ecc_pkg::ADDR_W-1:0] loop_pool [8];
    int unsigned                pick;
    foreach (loop_pool[i]) loop_pool[i] = $urandom();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        drive_item(ecc_pkg::OP_NEW_CASE, $urandom(), 16'($urandom()));
      else if (pick < 60)
        drive_item(ecc_pkg::OP_TRACE, loop_pool[$urandom_range(0, 7)], 16'($urandom()));
      else if (pick < 72)
        drive_item(ecc_pkg::OP_TRACE, $urandom(), 16'($urandom()));
      else if (pick < 84)
        drive_item(ecc_pkg::OP_READ, $urandom(), sb.last_edge);
      else if (pick < 95)
        drive_item(ecc_pkg::OP_READ, $urandom(), 16'($urandom()));
      else
        drive_item(OP_UNUSED, $urandom(), 16'($urandom()));
    end
  endtask

  initial begin : stimulus
    logic [ecc_pkg::LOG2_W-1:0] phase_log2 [12];
    sb = new();
    phase_log2 = '{5'd10, 5'd31, 5'd13, 5'd0, 5'd16, 5'd12,
                   5'd9, 5'd17, 5'd11, 5'd15, 5'd14, 5'd10};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.operation = ecc_pkg::OP_TRACE;
    in_if.block_address = '0;
    in_if.read_index = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    drive_item(ecc_pkg::OP_TRACE, 32'h0000_0000, 16'h0000);
    drive_item(ecc_pkg::OP_TRACE, 32'hFFFF_0000, 16'hFFFF);
    drive_item(ecc_pkg::OP_TRACE, 32'h0000_FFFF, 16'h0000);
    drive_item(ecc_pkg::OP_TRACE, 32'hFFFF_FFFF, 16'hFFFF);
    drive_item(ecc_pkg::OP_TRACE, 32'h1234_5678, 16'h5555);
    drive_item(ecc_pkg::OP_TRACE, 32'h1234_5678, 16'hAAAA);
    drive_item(ecc_pkg::OP_NEW_CASE, 32'hFFFF_FFFF, 16'hFFFF);
    drive_item(ecc_pkg::OP_TRACE, 32'h0000_0000, 16'h0000);
    drive_item(ecc_pkg::OP_TRACE, 32'h1234_5678, 16'h0000);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, 16'h0000);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, 16'hFFFF);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, 16'h8000);
    drive_item(ecc_pkg::OP_READ, 32'hFFFF_FFFF, 16'h7FFF);
    drive_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    drive_item(OP_UNUSED, 32'h0000_0000, 16'h0000);
    drive_item(ecc_pkg::OP_NEW_CASE, 32'h0000_0000, 16'h0000);
    settle();
    write_map_log2(ecc_pkg::MIN_LOG2);
    drive_item(ecc_pkg::OP_TRACE, 32'hABCD_1234, 16'h0000);
    drive_item(ecc_pkg::OP_TRACE, 32'hFFFF_0000, 16'h0000);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, 16'hFFFF);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, sb.last_edge);
    settle();
    write_map_log2(5'd5);
    drive_item(ecc_pkg::OP_TRACE, 32'hFFFF_0000, 16'h0000);
    drive_item(ecc_pkg::OP_TRACE, 32'h8000_0001, 16'h0000);

    gaps_on = 1'b1;
    rx_mode = RX_RUNS;
    hot_loop(HOT_LOOP_ITEMS);
    drive_item(ecc_pkg::OP_READ, 32'h0000_0000, 16'h0000);

    foreach (phase_log2[p]) begin
      settle();
      write_map_log2(phase_log2[p]);
      rx_mode = rx_mode_e'(p % 3);
      gaps_on = (p % 4) != 0;
      if (p == 2) long_hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/ecc_pkg.sv
design/ecc_if.sv
design/ecc_front.sv
design/ecc_queue.sv
design/ecc_back.sv
design/edge_coverage_counter_core.sv
design/ecc_checker.sv
sim/edge_coverage_counter_core_tb.sv
